/* rtl/index_block_merge_cost_unit_defines.svh */
// Assertion macros for the index block merge cost unit
`ifndef INDEX_BLOCK_MERGE_COST_UNIT_DEFINES_SVH
`define INDEX_BLOCK_MERGE_COST_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define IBMC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ibmc assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define IBMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ibmc assertion failed");

`endif

/* rtl/ibmc_pkg.sv */
// Package: types, constants and cost functions of the index block merge cost unit
package ibmc_pkg;

  localparam int unsigned BLOCK_LIMIT_BYTES = 65536;
  localparam int unsigned LOC_RECORD_BYTES  = 24;
  localparam int unsigned LIMIT_WORDS       = BLOCK_LIMIT_BYTES / 4;

  localparam int unsigned ID_W      = 64;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned COST_W    = 42;
  localparam int unsigned WORDS_W   = 36;
  localparam int unsigned DIV_STEPS = 2;

  localparam logic [COST_W-1:0] TOO_BIG_COST = COST_W'(64'hFFFF_FFFF);

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_MERGE = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    KIND_RANDOM    = 2'd0,
    KIND_UNIFORM   = 2'd1,
    KIND_MAGNITUDE = 2'd2,
    KIND_PREDICT   = 2'd3
  } kind_e;

  typedef struct packed {
    logic             start;
    logic [ID_W-1:0]  span;
    logic [CNT_W-1:0] count;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [ID_W-1:0] quot;
  } div_rsp_t;

  function automatic kind_e pick_kind(kind_e kind, logic uni, logic mag);
    kind_e res;
    case (kind)
      KIND_UNIFORM:   res = uni ? KIND_UNIFORM : KIND_RANDOM;
      KIND_MAGNITUDE: res = mag ? KIND_MAGNITUDE : KIND_RANDOM;
      KIND_PREDICT: begin
        if (uni) res = mag ? KIND_PREDICT : KIND_UNIFORM;
        else     res = mag ? KIND_MAGNITUDE : KIND_RANDOM;
      end
      default:        res = KIND_RANDOM;
    endcase
    return res;
  endfunction

  function automatic logic [COST_W-1:0] id_cost(kind_e src_k, kind_e dst_k,
                                                logic [CNT_W-1:0] cnt);
    logic [COST_W-1:0] c;
    logic [COST_W-1:0] res;
    c = COST_W'(cnt);
    case ({dst_k, src_k})
      {KIND_RANDOM, KIND_UNIFORM}:     res = (c << 2) - COST_W'(4);
      {KIND_RANDOM, KIND_MAGNITUDE}:   res = (c << 3) - COST_W'(8);
      {KIND_RANDOM, KIND_PREDICT}:     res = (c << 3) + (c << 2);
      {KIND_UNIFORM, KIND_PREDICT}:    res = c << 3;
      {KIND_MAGNITUDE, KIND_PREDICT}:  res = c << 2;
      default:                         res = TOO_BIG_COST;
    endcase
    if (src_k == dst_k) res = '0;
    return res;
  endfunction

  function automatic logic [COST_W-1:0] pg_cost(kind_e src_k, kind_e dst_k,
                                                logic [CNT_W-1:0] cnt);
    logic [COST_W-1:0] c;
    logic [COST_W-1:0] res;
    c = COST_W'(cnt);
    case ({dst_k, src_k})
      {KIND_RANDOM, KIND_UNIFORM}:     res = (c << 2) - COST_W'(4);
      {KIND_RANDOM, KIND_MAGNITUDE}:   res = (c << 3) - COST_W'(8);
      {KIND_RANDOM, KIND_PREDICT}:     res = (c << 3) + (c << 2) - COST_W'(12);
      {KIND_UNIFORM, KIND_PREDICT}:    res = (c << 3) - COST_W'(12);
      {KIND_MAGNITUDE, KIND_PREDICT}:  res = (c << 2) - COST_W'(12);
      default:                         res = TOO_BIG_COST;
    endcase
    if (src_k == dst_k) res = '0;
    return res;
  endfunction

endpackage

/* rtl/ibmc_div.sv */
// Shared signed span divider: 64-bit span by 32-bit count, two quotient bits per cycle
module ibmc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ibmc_pkg::div_req_t req_i,
  output ibmc_pkg::div_rsp_t rsp_o
);
  import ibmc_pkg::*;

  localparam int unsigned ITER_N = ID_W / DIV_STEPS;
  localparam int unsigned STEP_W = $clog2(ITER_N);

  typedef enum logic [3:0] {
    D_IDLE = 4'b0001,
    D_NEG  = 4'b0010,
    D_ITER = 4'b0100,
    D_FIX  = 4'b1000
  } div_state_e;

  div_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q;
  logic              done_q;
  logic [ID_W-1:0]   span_q;
  logic [CNT_W-1:0]  dvs_q;
  logic              neg_q;
  logic [ID_W-1:0]   quo_q, quo_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [ID_W-1:0]   quot_q;

  always_comb begin
    logic [CNT_W:0] shifted;
    logic [CNT_W:0] diff;
    logic           ge;
    quo_d = quo_q;
    rem_d = rem_q;
    for (int i = 0; i < DIV_STEPS; i++) begin
      shifted = {rem_d, quo_d[ID_W-1]};
      diff    = shifted - {1'b0, dvs_q};
      ge      = shifted >= {1'b0, dvs_q};
      rem_d   = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      quo_d   = {quo_d[ID_W-2:0], ge};
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      D_IDLE:  if (req_i.start) state_d = D_NEG;
      D_NEG:   state_d = D_ITER;
      D_ITER:  if (step_q == STEP_W'(ITER_N - 1)) state_d = D_FIX;
      D_FIX:   state_d = D_IDLE;
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == D_FIX);
      if (state_q == D_NEG)       step_q <= '0;
      else if (state_q == D_ITER) step_q <= step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      D_IDLE: begin
        if (req_i.start) begin
          span_q <= req_i.span;
          dvs_q  <= req_i.count;
        end
      end
      D_NEG: begin
        neg_q <= span_q[ID_W-1];
        quo_q <= span_q[ID_W-1] ? ('0 - span_q) : span_q;
        rem_q <= '0;
      end
      D_ITER: begin
        quo_q <= quo_d;
        rem_q <= rem_d;
      end
      D_FIX: begin
        // zero count leaves all ones unsigned
        quot_q <= (neg_q && (dvs_q != '0)) ? ('0 - quo_q) : quo_q;
      end
      default: ;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

/* rtl/index_block_merge_cost_unit.sv */
// Index block merge cost unit: accumulator, sequencer, cost sum and size limit check
//
// Holds one index block descriptor and rates candidate descriptors against it.
// A load transfer replaces the descriptor and returns a zero cost. A merge
// transfer runs the id-spacing test as two signed span divisions on one
// shared divider that retires two quotient bits a cycle, then sums four
// conversion costs on one adder and checks the size limit. One item is in
// work at a time; in_stall_o stays high until its result is in the output
// register, and a result waiting there does not stop the next input transfer.
module index_block_merge_cost_unit (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic                                    action_i,
  input  logic signed [ibmc_pkg::ID_W-1:0]        first_id_i,
  input  logic signed [ibmc_pkg::ID_W-1:0]        last_id_i,
  input  logic        [ibmc_pkg::ID_W-1:0]        first_page_i,
  input  logic        [ibmc_pkg::ID_W-1:0]        last_page_i,
  input  logic        [ibmc_pkg::CNT_W-1:0]       page_size_i,
  input  logic        [ibmc_pkg::CNT_W-1:0]       entry_count_i,
  input  logic        [1:0]                       id_kind_i,
  input  logic        [1:0]                       page_kind_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [ibmc_pkg::COST_W-1:0]      merge_cost_o,
  output logic        [1:0]                       merged_id_kind_o,
  output logic        [1:0]                       merged_page_kind_o,
  output logic                                    too_big_o
);
  import ibmc_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_START_A = 9'b000000010,
    S_RUN_A   = 9'b000000100,
    S_START_B = 9'b000001000,
    S_RUN_B   = 9'b000010000,
    S_COST    = 9'b000100000,
    S_COMMIT  = 9'b001000000,
    S_LIMIT   = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   in_xfer, out_free;

  // accumulator
  logic [ID_W-1:0]  acc_first_id_q, acc_last_id_q, acc_last_page_q;
  logic [CNT_W-1:0] acc_page_size_q, acc_count_q;
  kind_e            acc_id_kind_q, acc_page_kind_q;

  // captured item
  action_e          action_q;
  logic [ID_W-1:0]  f_id_q, l_id_q, f_pg_q, l_pg_q;
  logic [CNT_W-1:0] psize_q, cnt_q;
  kind_e            ik_q, pk_q;

  // work registers
  logic [ID_W-1:0]   qa_q;
  kind_e             idt_q, pgt_q;
  logic [COST_W-1:0] cost_q;
  logic [1:0]        term_q;
  logic              big_q;

  // output register
  logic              out_valid_q;
  logic [COST_W-1:0] out_cost_q;
  kind_e             out_ik_q, out_pk_q;
  logic              out_big_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic              uni_id;
  logic [COST_W-1:0] term;
  logic [CNT_W:0]    cnt_sum;
  logic [CNT_W-1:0]  cnt_sat;
  logic [ID_W-1:0]   id_span;
  logic [1:0]        idt_inv, pgt_inv;
  logic [2:0]        hdr_words, ent_words;
  logic [WORDS_W-1:0] blk_words;
  logic              big_now;

  assign in_xfer    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  ibmc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    div_req.start = (state_q == S_START_A) || (state_q == S_START_B);
    if (state_q == S_START_A) begin
      div_req.span  = acc_last_id_q - acc_first_id_q;
      div_req.count = acc_count_q;
    end else begin
      div_req.span  = l_id_q - f_id_q;
      div_req.count = cnt_q;
    end
  end

  assign uni_id = (qa_q == div_rsp.quot);

  always_comb begin
    case (term_q)
      2'd0:    term = id_cost(acc_id_kind_q, idt_q, acc_count_q);
      2'd1:    term = pg_cost(acc_page_kind_q, pgt_q, acc_count_q);
      2'd2:    term = id_cost(ik_q, idt_q, cnt_q);
      default: term = pg_cost(pk_q, pgt_q, cnt_q);
    endcase
  end

  assign cnt_sum = {1'b0, acc_count_q} + {1'b0, cnt_q};
  assign cnt_sat = cnt_sum[CNT_W] ? '1 : cnt_sum[CNT_W-1:0];

  // limit check on the committed accumulator
  assign id_span   = acc_last_id_q - acc_first_id_q;
  assign idt_inv   = ~acc_id_kind_q;
  assign pgt_inv   = ~acc_page_kind_q;
  assign hdr_words = 3'(acc_page_kind_q)
                   + ((acc_id_kind_q != KIND_PREDICT) ? 3'(acc_id_kind_q) : 3'd0);
  assign ent_words = 3'(idt_inv) + 3'(pgt_inv);
  assign blk_words = WORDS_W'(ent_words) * WORDS_W'(acc_count_q) + WORDS_W'(hdr_words);
  assign big_now   = (id_span[ID_W-1:32] != '0) || (blk_words > WORDS_W'(LIMIT_WORDS));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) state_d = (action_e'(action_i) == ACT_MERGE) ? S_START_A : S_DONE;
      end
      S_START_A: state_d = S_RUN_A;
      S_RUN_A:   if (div_rsp.done) state_d = S_START_B;
      S_START_B: state_d = S_RUN_B;
      S_RUN_B:   if (div_rsp.done) state_d = S_COST;
      S_COST:    if (term_q == 2'd3) state_d = S_COMMIT;
      S_COMMIT:  state_d = S_LIMIT;
      S_LIMIT:   state_d = S_DONE;
      S_DONE:    if (out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == S_DONE) && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i)               out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_first_id_q  <= '0;
      acc_last_id_q   <= '0;
      acc_last_page_q <= '0;
      acc_page_size_q <= '0;
      acc_count_q     <= '0;
      acc_id_kind_q   <= KIND_RANDOM;
      acc_page_kind_q <= KIND_RANDOM;
    end else if (state_q == S_COMMIT) begin
      acc_last_id_q   <= l_id_q;
      acc_last_page_q <= l_pg_q;
      acc_count_q     <= cnt_sat;
      acc_id_kind_q   <= idt_q;
      acc_page_kind_q <= pgt_q;
    end else if ((state_q == S_DONE) && out_free && (action_q == ACT_LOAD)) begin
      acc_first_id_q  <= f_id_q;
      acc_last_id_q   <= l_id_q;
      acc_last_page_q <= l_pg_q;
      acc_page_size_q <= psize_q;
      acc_count_q     <= cnt_q;
      acc_id_kind_q   <= ik_q;
      acc_page_kind_q <= pk_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      action_q <= action_e'(action_i);
      f_id_q   <= first_id_i;
      l_id_q   <= last_id_i;
      f_pg_q   <= first_page_i;
      l_pg_q   <= last_page_i;
      psize_q  <= page_size_i;
      cnt_q    <= entry_count_i;
      ik_q     <= kind_e'(id_kind_i);
      pk_q     <= kind_e'(page_kind_i);
    end
    if ((state_q == S_RUN_A) && div_rsp.done) qa_q <= div_rsp.quot;
    if ((state_q == S_RUN_B) && div_rsp.done) begin
      idt_q  <= pick_kind(kind_e'(acc_id_kind_q & ik_q), uni_id, acc_last_id_q == f_id_q);
      pgt_q  <= pick_kind(kind_e'(acc_page_kind_q & pk_q), acc_page_size_q == psize_q,
                          acc_last_page_q == f_pg_q);
      cost_q <= '0 - COST_W'(LOC_RECORD_BYTES);
      term_q <= 2'd0;
    end
    if (state_q == S_COST) begin
      cost_q <= cost_q + term;
      term_q <= term_q + 2'd1;
    end
    if (state_q == S_LIMIT) big_q <= big_now;
    if ((state_q == S_DONE) && out_free) begin
      if (action_q == ACT_LOAD) begin
        out_cost_q <= '0;
        out_ik_q   <= ik_q;
        out_pk_q   <= pk_q;
        out_big_q  <= 1'b0;
      end else begin
        out_cost_q <= big_q ? TOO_BIG_COST : cost_q;
        out_ik_q   <= acc_id_kind_q;
        out_pk_q   <= acc_page_kind_q;
        out_big_q  <= big_q;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign merge_cost_o       = $signed(out_cost_q);
  assign merged_id_kind_o   = out_ik_q;
  assign merged_page_kind_o = out_pk_q;
  assign too_big_o          = out_big_q;

endmodule

/* rtl/ibmc_checker.sv */
// Port-level checks of the index block merge cost unit and their bind
`include "index_block_merge_cost_unit_defines.svh"

module ibmc_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [ibmc_pkg::COST_W-1:0]  merge_cost_o,
  input logic                                too_big_o
);
  import ibmc_pkg::*;

  // busy right after an input transfer
  `IBMC_ASSERT_NEXT(a_busy_after_in, in_valid_i && !in_stall_o, in_stall_o)
  // a too-big result carries the fixed cost
  `IBMC_ASSERT_SAME(a_big_cost, out_valid_o && too_big_o, merge_cost_o == $signed(TOO_BIG_COST))
  // a new result follows a busy cycle
  `IBMC_ASSERT_SAME(a_result_after_work, $rose(out_valid_o), $past(in_stall_o))
  // a stalled result holds
  `IBMC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(merge_cost_o))

endmodule

bind index_block_merge_cost_unit ibmc_checker u_ibmc_checker (.*);

/* tb/tb_index_block_merge_cost_unit.sv */
// Testbench for the index block merge cost unit: directed and random descriptors vs. a local predictor
`timescale 1ns / 100ps

module tb_index_block_merge_cost_unit;
  import ibmc_pkg::*;

  localparam int unsigned CYCLE_LIMIT      = 1_000_000;
  localparam int unsigned DRAIN_CYCLES     = 200;
  localparam int unsigned HOLD_CYCLES      = 1500;
  localparam int unsigned RANDOM_PER_PHASE = 165;
  localparam int unsigned MAX_REPORTS      = 10;
  localparam longint      UNSUPPORTED_COST = 64'hFFFF_FFFF;

  typedef struct {
    action_e          act;
    logic [ID_W-1:0]  first_id;
    logic [ID_W-1:0]  last_id;
    logic [ID_W-1:0]  first_page;
    logic [ID_W-1:0]  last_page;
    logic [CNT_W-1:0] page_size;
    logic [CNT_W-1:0] entry_count;
    kind_e            id_kind;
    kind_e            page_kind;
  } block_desc_t;

  typedef struct {
    logic [COST_W-1:0] cost;
    kind_e             id_kind;
    kind_e             page_kind;
    logic              too_big;
  } merge_outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic action_i = 1'b0;
  logic [ID_W-1:0] first_id_i = '0;
  logic [ID_W-1:0] last_id_i = '0;
  logic [ID_W-1:0] first_page_i = '0;
  logic [ID_W-1:0] last_page_i = '0;
  logic [CNT_W-1:0] page_size_i = '0;
  logic [CNT_W-1:0] entry_count_i = 32'd1;
  logic [1:0] id_kind_i = '0;
  logic [1:0] page_kind_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [COST_W-1:0] merge_cost_o;
  logic [1:0] merged_id_kind_o;
  logic [1:0] merged_page_kind_o;
  logic too_big_o;

  // predicted accumulator
  logic [ID_W-1:0]  blk_first_id = '0;
  logic [ID_W-1:0]  blk_last_id = '0;
  logic [ID_W-1:0]  blk_last_page = '0;
  logic [CNT_W-1:0] blk_page_size = '0;
  logic [CNT_W-1:0] blk_count = '0;
  kind_e            blk_id_kind = KIND_RANDOM;
  kind_e            blk_page_kind = KIND_RANDOM;

  merge_outcome_t expected_q[$];
  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned cycle_count = 0;
  int unsigned src_idle_pct = 0;
  int unsigned rcv_stall_pct = 0;
  logic        hold_on = 1'b0;
  event        hold_go;
  int unsigned chain_left = 0;
  longint      chain_stride = 0;

  always #5 clk_i = ~clk_i;

  index_block_merge_cost_unit DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .action_i           (action_i),
    .first_id_i         (first_id_i),
    .last_id_i          (last_id_i),
    .first_page_i       (first_page_i),
    .last_page_i        (last_page_i),
    .page_size_i        (page_size_i),
    .entry_count_i      (entry_count_i),
    .id_kind_i          (id_kind_i),
    .page_kind_i        (page_kind_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .merge_cost_o       (merge_cost_o),
    .merged_id_kind_o   (merged_id_kind_o),
    .merged_page_kind_o (merged_page_kind_o),
    .too_big_o          (too_big_o)
  );

  // signed span divided by count, truncating; zero count gives all ones
  function automatic logic [ID_W-1:0] id_spacing(logic [ID_W-1:0] first, logic [ID_W-1:0] last,
                                                 logic [CNT_W-1:0] cnt);
    logic [ID_W-1:0] span;
    logic [ID_W-1:0] mag;
    logic [ID_W-1:0] quot;
    span = last - first;
    mag = span[ID_W-1] ? (64'd0 - span) : span;
    if (cnt == 0) return '1;
    quot = mag / {32'd0, cnt};
    return span[ID_W-1] ? (64'd0 - quot) : quot;
  endfunction

  function automatic kind_e settle_kind(kind_e k, bit uni, bit mag);
    if (k == KIND_UNIFORM) begin
      if (uni) return KIND_UNIFORM;
    end else if (k == KIND_MAGNITUDE) begin
      if (mag) return KIND_MAGNITUDE;
    end else if (k == KIND_PREDICT) begin
      if (uni && mag) return KIND_PREDICT;
      if (uni) return KIND_UNIFORM;
      if (mag) return KIND_MAGNITUDE;
    end
    return KIND_RANDOM;
  endfunction

  function automatic longint convert_cost(bit is_page, kind_e from, kind_e to,
                                          logic [CNT_W-1:0] cnt);
    longint c;
    c = longint'(cnt);
    if (from == to) return 0;
    if (to == KIND_RANDOM && from == KIND_UNIFORM) return 4 * c - 4;
    if (to == KIND_RANDOM && from == KIND_MAGNITUDE) return 8 * c - 8;
    if (to == KIND_RANDOM && from == KIND_PREDICT) return is_page ? 12 * (c - 1) : 12 * c;
    if (to == KIND_UNIFORM && from == KIND_PREDICT) return is_page ? 8 * c - 12 : 8 * c;
    if (to == KIND_MAGNITUDE && from == KIND_PREDICT) return is_page ? 4 * c - 12 : 4 * c;
    return UNSUPPORTED_COST;
  endfunction

  // updates the predicted accumulator and returns the expected result
  function automatic merge_outcome_t rate_descriptor(block_desc_t d);
    merge_outcome_t r;
    kind_e ik;
    kind_e pk;
    bit uni;
    bit mag;
    bit big;
    longint cost;
    logic [CNT_W:0] sum;
    logic [ID_W-1:0] span;
    logic [63:0] hdr;
    logic [63:0] ent;
    if (d.act == ACT_LOAD) begin
      blk_first_id = d.first_id;
      blk_last_id = d.last_id;
      blk_last_page = d.last_page;
      blk_page_size = d.page_size;
      blk_count = d.entry_count;
      blk_id_kind = d.id_kind;
      blk_page_kind = d.page_kind;
      r.cost = '0;
      r.id_kind = d.id_kind;
      r.page_kind = d.page_kind;
      r.too_big = 1'b0;
      return r;
    end
    uni = id_spacing(blk_first_id, blk_last_id, blk_count) ==
          id_spacing(d.first_id, d.last_id, d.entry_count);
    mag = blk_last_id == d.first_id;
    ik = settle_kind(kind_e'(blk_id_kind & d.id_kind), uni, mag);
    uni = blk_page_size == d.page_size;
    mag = blk_last_page == d.first_page;
    pk = settle_kind(kind_e'(blk_page_kind & d.page_kind), uni, mag);
    cost = convert_cost(1'b0, blk_id_kind, ik, blk_count)
         + convert_cost(1'b1, blk_page_kind, pk, blk_count)
         + convert_cost(1'b0, d.id_kind, ik, d.entry_count)
         + convert_cost(1'b1, d.page_kind, pk, d.entry_count);
    blk_last_id = d.last_id;
    blk_last_page = d.last_page;
    sum = {1'b0, blk_count} + {1'b0, d.entry_count};
    blk_count = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
    blk_id_kind = ik;
    blk_page_kind = pk;
    big = 1'b1;
    span = blk_last_id - blk_first_id;
    if (span[63:32] == 0) begin
      hdr = 64'(pk);
      if (ik != KIND_PREDICT) hdr = hdr + 64'(ik);
      ent = 64'(ik ^ KIND_PREDICT) + 64'(pk ^ KIND_PREDICT);
      if (hdr + ent * 64'(blk_count) <= 64'(LIMIT_WORDS)) big = 1'b0;
    end
    r.cost = big ? TOO_BIG_COST : COST_W'(cost - longint'(LOC_RECORD_BYTES));
    r.id_kind = ik;
    r.page_kind = pk;
    r.too_big = big;
    return r;
  endfunction

  function automatic block_desc_t make_block(action_e act, logic [63:0] fid, logic [63:0] lid,
                                             logic [63:0] fpg, logic [63:0] lpg,
                                             logic [31:0] psz, logic [31:0] cnt,
                                             kind_e ik, kind_e pk);
    block_desc_t d;
    d.act = act;
    d.first_id = fid;
    d.last_id = lid;
    d.first_page = fpg;
    d.last_page = lpg;
    d.page_size = psz;
    d.entry_count = cnt;
    d.id_kind = ik;
    d.page_kind = pk;
    return d;
  endfunction

  function automatic kind_e high_kind();
    return ($urandom_range(99) < 60) ? KIND_PREDICT : kind_e'($urandom_range(3));
  endfunction

  // mostly load-then-merge chains that keep ids and pages contiguous; some broken, some noise
  function automatic block_desc_t random_descriptor();
    block_desc_t d;
    int unsigned roll;
    d.act = action_e'($urandom_range(1));
    d.first_id = {$urandom, $urandom};
    d.last_id = {$urandom, $urandom};
    d.first_page = {$urandom, $urandom};
    d.last_page = {$urandom, $urandom};
    d.page_size = $urandom;
    d.entry_count = $urandom;
    if (d.entry_count == 0) d.entry_count = 32'd1;
    d.id_kind = kind_e'($urandom_range(3));
    d.page_kind = kind_e'($urandom_range(3));
    roll = $urandom_range(99);
    if (chain_left == 0 && roll < 88) begin
      d.act = ACT_LOAD;
      chain_left = $urandom_range(1, 6);
      chain_stride = longint'($urandom_range(16)) - 4;
      d.entry_count = $urandom_range(1, 64);
      if ($urandom_range(1)) d.first_id = 64'($urandom_range(100000));
      d.last_id = d.first_id + 64'(chain_stride * longint'(d.entry_count));
      d.last_page = d.first_page + 64'($urandom_range(1, 4096));
      if ($urandom_range(1)) d.page_size = $urandom_range(1, 4096);
      d.id_kind = high_kind();
      d.page_kind = high_kind();
    end else if (chain_left != 0) begin
      chain_left--;
      d.act = ACT_MERGE;
      if (roll < 92) begin
        d.entry_count = $urandom_range(1, 64);
        d.first_id = blk_last_id;
        d.last_id = d.first_id + 64'(chain_stride * longint'(d.entry_count));
        d.first_page = blk_last_page;
        d.last_page = d.first_page + 64'($urandom_range(1, 4096));
        d.page_size = blk_page_size;
        d.id_kind = high_kind();
        d.page_kind = high_kind();
        if (roll >= 75) begin
          case ($urandom_range(3))
            0: d.first_id = d.first_id + 64'($urandom_range(1, 8));
            1: d.last_id = d.last_id + 64'($urandom_range(1, 8));
            2: d.page_size = d.page_size ^ (32'd1 << $urandom_range(31));
            default: d.first_page = d.first_page + 64'($urandom_range(1, 8));
          endcase
        end
      end
    end
    return d;
  endfunction

  task automatic flag_error(input string what, input logic [63:0] want, input logic [63:0] got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("mismatch %s: expected %h, got %h", what, want, got);
  endtask

  task automatic set_idling(input int unsigned src_pct, input int unsigned rcv_pct);
    src_idle_pct = src_pct;
    rcv_stall_pct <= rcv_pct;
  endtask

  task automatic send_item(input block_desc_t d);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= d.act;
    first_id_i <= d.first_id;
    last_id_i <= d.last_id;
    first_page_i <= d.first_page;
    last_page_i <= d.last_page;
    page_size_i <= d.page_size;
    entry_count_i <= d.entry_count;
    id_kind_i <= d.id_kind;
    page_kind_i <= d.page_kind;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_q.push_back(rate_descriptor(d));
    items_sent++;
  endtask

  // accumulator still zero, so the spacing test divides by a zero count
  task automatic test_merge_after_reset();
    send_item(make_block(ACT_MERGE, 64'd10, 64'd5, 64'd0, 64'd77, 32'd9, 32'd5,
                         KIND_PREDICT, KIND_PREDICT));
  endtask

  task automatic test_field_extremes();
    send_item(make_block(ACT_LOAD, '1, '1, '1, '1, '1, '1, KIND_PREDICT, KIND_PREDICT));
    send_item(make_block(ACT_MERGE, '1, '1, '1, '1, '1, '1, KIND_PREDICT, KIND_PREDICT));
    send_item(make_block(ACT_LOAD, '0, '0, '0, '0, '0, 32'd1, KIND_RANDOM, KIND_RANDOM));
    send_item(make_block(ACT_LOAD, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                         64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                         32'hAAAA_AAAA, 32'h5555_5555, KIND_UNIFORM, KIND_MAGNITUDE));
    send_item(make_block(ACT_MERGE, '1, '1, '1, '1, '1, '1, KIND_PREDICT, KIND_PREDICT));
  endtask

  task automatic test_encoding_fallback();
    send_item(make_block(ACT_LOAD, 64'd1000, 64'd1032, 64'd0, 64'd512, 32'd64, 32'd8,
                         KIND_PREDICT, KIND_PREDICT));
    send_item(make_block(ACT_MERGE, 64'd1032, 64'd1064, 64'd512, 64'd1024, 32'd64, 32'd8,
                         KIND_PREDICT, KIND_PREDICT));
    send_item(make_block(ACT_MERGE, 64'd1064, 64'd1104, 64'd1024, 64'd1500, 32'd128, 32'd8,
                         KIND_PREDICT, KIND_PREDICT));
    send_item(make_block(ACT_LOAD, 64'd1000, 64'd1032, 64'd0, 64'd512, 32'd64, 32'd8,
                         KIND_PREDICT, KIND_PREDICT));
    send_item(make_block(ACT_MERGE, 64'd2000, 64'd2032, 64'd999, 64'd1200, 32'd64, 32'd8,
                         KIND_PREDICT, KIND_PREDICT));
    send_item(make_block(ACT_MERGE, 64'd3000, 64'd3080, 64'd1200, 64'd1300, 32'd32, 32'd8,
                         KIND_UNIFORM, KIND_UNIFORM));
    send_item(make_block(ACT_LOAD, 64'd0, 64'd16, 64'd100, 64'd200, 32'd16, 32'd4,
                         KIND_MAGNITUDE, KIND_MAGNITUDE));
    send_item(make_block(ACT_MERGE, 64'd16, 64'd40, 64'd200, 64'd300, 32'd8, 32'd4,
                         KIND_MAGNITUDE, KIND_MAGNITUDE));
    send_item(make_block(ACT_MERGE, 64'd50, 64'd60, 64'd333, 64'd400, 32'd8, 32'd4,
                         KIND_MAGNITUDE, KIND_MAGNITUDE));
    send_item(make_block(ACT_LOAD, 64'd0, 64'd8, 64'd0, 64'd64, 32'd8, 32'd2,
                         KIND_UNIFORM, KIND_MAGNITUDE));
    send_item(make_block(ACT_MERGE, 64'd8, 64'd16, 64'd64, 64'd128, 32'd8, 32'd2,
                         KIND_MAGNITUDE, KIND_UNIFORM));
    send_item(make_block(ACT_MERGE, 64'd16, 64'd24, 64'd128, 64'd192, 32'd8, 32'd2,
                         KIND_PREDICT, KIND_PREDICT));
  endtask

  task automatic test_size_limits();
    send_item(make_block(ACT_LOAD, 64'd0, 64'd100, 64'd0, 64'd10, 32'd4, 32'd10,
                         KIND_PREDICT, KIND_PREDICT));
    send_item(make_block(ACT_MERGE, 64'd100, 64'h1_0000_0000, 64'd10, 64'd20, 32'd4, 32'd10,
                         KIND_PREDICT, KIND_PREDICT));
    send_item(make_block(ACT_LOAD, 64'd0, 64'd100, 64'd0, 64'd10, 32'd4, 32'd10,
                         KIND_PREDICT, KIND_PREDICT));
    send_item(make_block(ACT_MERGE, 64'd100, 64'hFFFF_FFFF, 64'd10, 64'd20, 32'd4, 32'd10,
                         KIND_PREDICT, KIND_PREDICT));
    // six words per entry: 2730 entries fit, 2731 do not
    send_item(make_block(ACT_LOAD, 64'd0, 64'd1000, 64'd0, 64'd10, 32'd4, 32'd1000,
                         KIND_RANDOM, KIND_RANDOM));
    send_item(make_block(ACT_MERGE, 64'd1000, 64'd2730, 64'd10, 64'd20, 32'd4, 32'd1730,
                         KIND_RANDOM, KIND_RANDOM));
    send_item(make_block(ACT_LOAD, 64'd0, 64'd1000, 64'd0, 64'd10, 32'd4, 32'd1000,
                         KIND_RANDOM, KIND_RANDOM));
    send_item(make_block(ACT_MERGE, 64'd1000, 64'd2731, 64'd10, 64'd20, 32'd4, 32'd1731,
                         KIND_RANDOM, KIND_RANDOM));
  endtask

  task automatic test_random_traffic();
    int unsigned src_pct[4] = '{0, 66, 0, 18};
    int unsigned rcv_pct[4] = '{0, 0, 66, 18};
    for (int p = 0; p < 4; p++) begin
      set_idling(src_pct[p], rcv_pct[p]);
      repeat (RANDOM_PER_PHASE) send_item(random_descriptor());
    end
  endtask

  // output held off long enough that the input side backs up
  task automatic test_output_hold();
    set_idling(0, 0);
    -> hold_go;
    repeat (10) send_item(random_descriptor());
  endtask

  initial forever begin
    @(hold_go);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= hold_on || ($urandom_range(99) < rcv_stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    merge_outcome_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        flag_error("result with none pending", '0, 64'(merge_cost_o));
      end else begin
        want = expected_q.pop_front();
        results_checked++;
        if (merge_cost_o !== want.cost)
          flag_error("merge_cost", 64'(want.cost), 64'(merge_cost_o));
        if (merged_id_kind_o !== want.id_kind)
          flag_error("merged_id_kind", 64'(want.id_kind), 64'(merged_id_kind_o));
        if (merged_page_kind_o !== want.page_kind)
          flag_error("merged_page_kind", 64'(want.page_kind), 64'(merged_page_kind_o));
        if (too_big_o !== want.too_big)
          flag_error("too_big", 64'(want.too_big), 64'(too_big_o));
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_merge_after_reset();
    test_field_extremes();
    test_encoding_fallback();
    test_size_limits();
    test_random_traffic();
    test_output_hold();
    in_valid_i <= 1'b0;
    rcv_stall_pct <= 0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_q.size() != 0) flag_error("results missing", '0, 64'(expected_q.size()));
    $display("Sent %0d descriptors (loads, merges, limit cases), checked %0d results.",
             items_sent, results_checked);
    $display("Traffic ran with and without idling on both sides and one long output hold.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
